// ===== rtl/core/sor_pkg.sv =====
// Shared types and constants for the spiral order reader.
`default_nettype none

package sor_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int DIM_W       = 5;
    localparam int IDX_W       = 4;
    localparam int ELEM_W      = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = CFG_INDEX_W'(1);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EMIT = 1'b1;

    typedef struct packed {
        logic                     action;
        logic signed [ELEM_W-1:0] element_value;
    } sor_in_item_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element_value_out;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic                     last_of_spiral;
        logic                     status;
    } sor_out_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic             last_of_spiral;
        logic             status;
    } sor_meta_t;

endpackage

`default_nettype wire

// ===== rtl/core/sor_chan_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
`default_nettype none

interface sor_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sor_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none

interface sor_cfg_if;
    import sor_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spiral_order_reader_top.sv =====
// Spiral order reader: row-major load, clockwise spiral readout of a matrix.
// Throughput: one transaction per cycle on the request channel when rsp is ready.
// An emit result reaches rsp through the registered store read and then the output
//   register.
// Loads produce no result; a load may follow an emit in the next cycle.
// Reset clears all control state; the element store is not cleared and is read
//   only at entries already written.
`default_nettype none

module spiral_order_reader_top #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sor_cfg_if.sink    cfg,
    sor_chan_if.sink   req,
    sor_chan_if.source rsp
);
    import sor_pkg::*;

    localparam int AW = $clog2(MAX_ROWS*MAX_COLS);

    logic                  take;
    logic                  item_fire;
    logic                  cfg_we;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic                  issue;
    sor_meta_t             meta;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;
    assign req.ready = take;
    assign item_fire = req.valid && req.ready;

    sor_ctrl #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .item_fire (item_fire),
        .item      (req.payload),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .issue     (issue),
        .meta      (meta)
    );

    sor_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_ROWS*MAX_COLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sor_out #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (issue),
        .meta  (meta),
        .rdata (ram_rdata),
        .take  (take),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/core/sor_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sor_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sor_ctrl.sv =====
// Load counters, spiral walker with shrinking bounds, and store access control.
`default_nettype none

module sor_ctrl #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       cfg_we,
    input  wire logic [sor_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  wire logic [sor_pkg::CFG_DATA_W-1:0]             cfg_data,
    input  wire logic                                       item_fire,
    input  wire sor_pkg::sor_in_item_t                      item,
    output logic                                            ram_we,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]            ram_waddr,
    output logic [DATA_WIDTH-1:0]                           ram_wdata,
    output logic                                            ram_re,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]            ram_raddr,
    output logic                                            issue,
    output sor_pkg::sor_meta_t                              meta
);
    import sor_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = $clog2(MAX_ROWS*MAX_COLS);
    localparam int ER = (MAX_ROWS < 31) ? MAX_ROWS : 31;
    localparam int EC = (MAX_COLS < 31) ? MAX_COLS : 31;
    localparam int NW = $clog2(ER*EC + 1);

    typedef enum logic [1:0] {
        HEAD_RIGHT,
        HEAD_DOWN,
        HEAD_LEFT,
        HEAD_UP
    } heading_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    logic [DIM_W-1:0] rows_reg, rows_next;
    logic [DIM_W-1:0] cols_reg, cols_next;
    logic [RW-1:0]    load_row_reg, load_row_next;
    logic [CW-1:0]    load_col_reg, load_col_next;
    logic             load_done_reg, load_done_next;
    logic [NW-1:0]    emit_cnt_reg, emit_cnt_next;
    logic [RW-1:0]    cur_row_reg, cur_row_next;
    logic [CW-1:0]    cur_col_reg, cur_col_next;
    heading_t         heading_reg, heading_next;
    logic [RW-1:0]    top_reg, top_next;
    logic [RW-1:0]    bottom_reg, bottom_next;
    logic [CW-1:0]    left_reg, left_next;
    logic [CW-1:0]    right_reg, right_next;

    logic [NW-1:0]    total;
    logic             emit_ok;
    logic             emit_last;
    logic [RW-1:0]    ld_row;
    logic [CW-1:0]    ld_col;
    logic [DIM_W-1:0] new_rows;
    logic [DIM_W-1:0] new_cols;
    logic [63:0]      wide_value;

    assign total      = NW'(rows_reg) * NW'(cols_reg);
    assign emit_ok    = load_done_reg && (emit_cnt_reg < total);
    assign emit_last  = ((emit_cnt_reg + NW'(1)) == total);
    assign ld_row     = load_done_reg ? '0 : load_row_reg;
    assign ld_col     = load_done_reg ? '0 : load_col_reg;
    assign wide_value = {32'b0, item.element_value};
    assign new_rows   = (cfg_index == REG_ROW_COUNT)
                        ? eff_dim(cfg_data[DIM_W-1:0], DIM_W'(ER)) : rows_reg;
    assign new_cols   = (cfg_index == REG_COL_COUNT)
                        ? eff_dim(cfg_data[DIM_W-1:0], DIM_W'(EC)) : cols_reg;

    always_comb
    begin
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        load_done_next = load_done_reg;
        emit_cnt_next  = emit_cnt_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        heading_next   = heading_reg;
        top_next       = top_reg;
        bottom_next    = bottom_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        ram_we         = 1'b0;
        ram_waddr      = cell_addr(ld_row, ld_col);
        ram_wdata      = wide_value[DATA_WIDTH-1:0];
        ram_re         = 1'b0;
        ram_raddr      = cell_addr(cur_row_reg, cur_col_reg);
        issue          = 1'b0;
        meta           = '0;
        meta.status    = 1'b1;

        if (cfg_we && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT))
        begin
            // restart loading and the spiral with the new dimensions
            rows_next      = new_rows;
            cols_next      = new_cols;
            load_row_next  = '0;
            load_col_next  = '0;
            load_done_next = 1'b0;
            emit_cnt_next  = '0;
            cur_row_next   = '0;
            cur_col_next   = '0;
            heading_next   = HEAD_RIGHT;
            top_next       = '0;
            left_next      = '0;
            bottom_next    = RW'(new_rows - DIM_W'(1));
            right_next     = CW'(new_cols - DIM_W'(1));
        end
        else if (item_fire)
        begin
            if (item.action == ACT_LOAD)
            begin
                if (load_done_reg)
                begin
                    load_done_next = 1'b0;
                    emit_cnt_next  = '0;
                    cur_row_next   = '0;
                    cur_col_next   = '0;
                    heading_next   = HEAD_RIGHT;
                    top_next       = '0;
                    left_next      = '0;
                    bottom_next    = RW'(rows_reg - DIM_W'(1));
                    right_next     = CW'(cols_reg - DIM_W'(1));
                end
                ram_we = 1'b1;
                if (ld_col == CW'(cols_reg - DIM_W'(1)))
                begin
                    load_col_next = '0;
                    load_row_next = ld_row;
                    if (ld_row == RW'(rows_reg - DIM_W'(1)))
                        load_done_next = 1'b1;
                    else
                        load_row_next = ld_row + RW'(1);
                end
                else
                begin
                    load_row_next = ld_row;
                    load_col_next = ld_col + CW'(1);
                end
            end
            else
            begin
                issue = 1'b1;
                if (emit_ok)
                begin
                    ram_re              = 1'b1;
                    meta.row_index      = IDX_W'(cur_row_reg);
                    meta.col_index      = IDX_W'(cur_col_reg);
                    meta.last_of_spiral = emit_last;
                    meta.status         = 1'b0;
                    emit_cnt_next       = emit_cnt_reg + NW'(1);
                    if (!emit_last)
                    begin
                        case (heading_reg)
                            HEAD_RIGHT:
                            begin
                                if (cur_col_reg < right_reg)
                                    cur_col_next = cur_col_reg + CW'(1);
                                else
                                begin
                                    top_next     = top_reg + RW'(1);
                                    heading_next = HEAD_DOWN;
                                    cur_row_next = cur_row_reg + RW'(1);
                                end
                            end
                            HEAD_DOWN:
                            begin
                                if (cur_row_reg < bottom_reg)
                                    cur_row_next = cur_row_reg + RW'(1);
                                else
                                begin
                                    right_next   = right_reg - CW'(1);
                                    heading_next = HEAD_LEFT;
                                    cur_col_next = cur_col_reg - CW'(1);
                                end
                            end
                            HEAD_LEFT:
                            begin
                                if (cur_col_reg > left_reg)
                                    cur_col_next = cur_col_reg - CW'(1);
                                else
                                begin
                                    bottom_next  = bottom_reg - RW'(1);
                                    heading_next = HEAD_UP;
                                    cur_row_next = cur_row_reg - RW'(1);
                                end
                            end
                            default:
                            begin
                                if (cur_row_reg > top_reg)
                                    cur_row_next = cur_row_reg - RW'(1);
                                else
                                begin
                                    left_next    = left_reg + CW'(1);
                                    heading_next = HEAD_RIGHT;
                                    cur_col_next = cur_col_reg + CW'(1);
                                end
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= DIM_W'(1);
            cols_reg      <= DIM_W'(1);
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            load_done_reg <= 1'b0;
            emit_cnt_reg  <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            heading_reg   <= HEAD_RIGHT;
            top_reg       <= '0;
            bottom_reg    <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
        end
        else
        begin
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            load_done_reg <= load_done_next;
            emit_cnt_reg  <= emit_cnt_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            heading_reg   <= heading_next;
            top_reg       <= top_next;
            bottom_reg    <= bottom_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
        end
    end

    a_no_emit_before_load: assert property (@(posedge clk) disable iff (!rst_n)
        !load_done_reg |-> emit_cnt_reg == '0)
        else $error("emit count moved before the load completed");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= total)
        else $error("emit count beyond the matrix size");

    a_read_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (cur_row_reg >= top_reg && cur_row_reg <= bottom_reg
                    && cur_col_reg >= left_reg && cur_col_reg <= right_reg))
        else $error("spiral read outside the current bounds");

endmodule

`default_nettype wire

// ===== rtl/core/sor_out.sv =====
// Read-return stage and output register with backpressure.
`default_nettype none

module sor_out #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               issue,
    input  wire sor_pkg::sor_meta_t meta,
    input  wire logic [DATA_WIDTH-1:0] rdata,
    output logic                    take,
    sor_chan_if.source              rsp
);
    import sor_pkg::*;

    logic          s1_valid_reg, s1_valid_next;
    sor_meta_t     s1_meta_reg;
    logic          out_valid_reg, out_valid_next;
    sor_out_item_t out_item_reg;
    logic          out_free;
    logic          s1_move;
    logic [63:0]   wide_rdata;

    assign out_free      = !out_valid_reg || rsp.ready;
    assign s1_move       = s1_valid_reg && out_free;
    assign take          = !s1_valid_reg || s1_move;
    assign wide_rdata    = 64'(rdata);
    assign s1_valid_next = issue ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_meta_reg <= meta;
        end
        if (s1_move)
        begin
            out_item_reg.element_value_out <= s1_meta_reg.status ? '0 : wide_rdata[31:0];
            out_item_reg.row_index         <= s1_meta_reg.row_index;
            out_item_reg.col_index         <= s1_meta_reg.col_index;
            out_item_reg.last_of_spiral    <= s1_meta_reg.last_of_spiral;
            out_item_reg.status            <= s1_meta_reg.status;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |-> !issue)
        else $error("pending read return overwritten");

    a_issue_lands: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> s1_valid_reg)
        else $error("accepted request lost in the return stage");

    a_stall_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_meta_reg)))
        else $error("return stage changed while output stalled");

endmodule

`default_nettype wire
